FILE: rtl/core/mer_pkg.sv
// Shared types and constants of the midpoint ellipse raster unit.
// Used by the channel interfaces and by the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  // Field widths fixed by the channel payloads
  localparam int CTR_W           = 11;
  localparam int RAD_W           = 10;
  localparam int PT_W            = 14;
  localparam int ORG_W           = 12;
  localparam int CFG_IDX_W       = 1;
  localparam int RADIUS_BITS_DEF = 10;

  localparam logic [ORG_W-1:0] ORIGIN_RESET = 12'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 1'b0,
    CFG_ORIGIN_Y = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } act_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RX,
    ST_SQ_RY,
    ST_YTERM,
    ST_SEED_XX,
    ST_SEED_A,
    ST_SEED_YY,
    ST_SEED_B,
    ST_SEED_C,
    ST_STEP,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    EM_AXIS,
    EM_STEP,
    EM_NULL
  } emit_e;

endpackage

`default_nettype wire

FILE: rtl/core/mer_in_if.sv
// Input channel of the ellipse raster unit: valid/ready plus one command item.
// Depends on mer_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mer_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic signed [mer_pkg::CTR_W-1:0]  center_x;
  logic signed [mer_pkg::CTR_W-1:0]  center_y;
  logic        [mer_pkg::RAD_W-1:0]  rad_x;
  logic        [mer_pkg::RAD_W-1:0]  rad_y;

  modport source (output valid, action, center_x, center_y, rad_x, rad_y,
                  input ready);
  modport sink (input valid, action, center_x, center_y, rad_x, rad_y,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mer_out_if.sv
// Output channel of the ellipse raster unit: valid/ready plus four screen points.
// Depends on mer_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mer_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [mer_pkg::PT_W-1:0] pt0_x;
  logic signed [mer_pkg::PT_W-1:0] pt0_y;
  logic signed [mer_pkg::PT_W-1:0] pt1_x;
  logic signed [mer_pkg::PT_W-1:0] pt1_y;
  logic signed [mer_pkg::PT_W-1:0] pt2_x;
  logic signed [mer_pkg::PT_W-1:0] pt2_y;
  logic signed [mer_pkg::PT_W-1:0] pt3_x;
  logic signed [mer_pkg::PT_W-1:0] pt3_y;
  logic                            points_valid;
  logic                            last_step;

  modport source (output valid, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y,
                  points_valid, last_step, input ready);
  modport sink (input valid, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y,
                points_valid, last_step, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/midpoint_ellipse_raster_unit.sv
// Midpoint ellipse raster unit: sequencer around one shared multiplier.
// Depends on mer_pkg, mer_in_if and mer_out_if.
`timescale 1ns / 1ps
`default_nettype none

// A start command latches the centre and radii, squares the radii and sets up
// the step terms over three multiplier passes; its four axis points are then
// loaded into the output register from the emit state. An advance command runs
// one midpoint step in a single add/compare state and its result is loaded from
// the emit state. The advance that crosses from region 1 into region 2 first
// seeds the region-2 decision with five passes through the shared multiplier.
// An advance with no ellipse in progress goes straight to the emit state and
// loads an all-zero result. The unit takes one command at a time and is ready
// only while the sequencer is idle, so a new transfer can follow only once the
// result is loaded; a stalled output register holds the sequencer in the emit
// state and delays it further. A finished result waits in the output register
// while the next command is taken. Screen x is origin_x plus user x, screen y
// is origin_y minus user y, all points wrap to 14 bits.
module midpoint_ellipse_raster_unit #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [mer_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [mer_pkg::ORG_W-1:0]       cfg_data_i,
  mer_in_if.sink                          in_i,
  mer_out_if.source                       out_o
);

  localparam int RB  = RADIUS_BITS;
  localparam int XW  = RB + 1;
  localparam int SQW = 2 * RB;
  localparam int SW  = 3 * RB + 3;
  localparam int DW  = 4 * RB + 4;
  localparam int MAW = 2 * RB;
  localparam int MBW = 2 * RB + 3;
  localparam int MPW = MAW + MBW;
  localparam int PW  = mer_pkg::PT_W;
  localparam int CW  = mer_pkg::CTR_W;
  localparam int OW  = mer_pkg::ORG_W;
  localparam int RIW = RB + mer_pkg::RAD_W;

  mer_pkg::state_e state_q, state_d;
  mer_pkg::emit_e  kind_q, kind_d;

  logic                  active_q, active_d;
  logic                  r2_q, r2_d;
  logic                  last_q, last_d;
  logic [XW-1:0]         x_q, x_d;
  logic [RB-1:0]         y_q, y_d;
  logic signed [SW-1:0]  xs_q, xs_d;
  logic signed [SW-1:0]  ys_q, ys_d;
  logic signed [DW-1:0]  dec_q, dec_d;
  logic [SQW-1:0]        rx2_q, rx2_d;
  logic [SQW-1:0]        ry2_q, ry2_d;
  logic [RB-1:0]         rx_q, rx_d;
  logic [RB-1:0]         ry_q, ry_d;
  logic [PW-1:0]         csx_q, csx_d;
  logic [PW-1:0]         csy_q, csy_d;
  logic [MBW-1:0]        tmp_q, tmp_d;
  logic [OW-1:0]         org_x_q, org_y_q;

  logic                  out_vld_q;
  logic [PW-1:0]         opt_q [8];
  logic [PW-1:0]         opt_d [8];
  logic                  out_pv_q, out_pv_d;
  logic                  out_last_q;

  logic                  in_fire;
  logic                  out_load;
  logic [RIW-1:0]        rx_wide, ry_wide;
  logic [RB-1:0]         rx_in, ry_in;
  logic [RB-1:0]         y_m1;

  logic [MAW-1:0]        mul_a;
  logic [MBW-1:0]        mul_b;
  logic [MPW-1:0]        mul_p;
  logic signed [DW-1:0]  mul_s;

  logic signed [SW-1:0]  two_rx2, two_ry2;
  logic signed [SW-1:0]  xs_inc, ys_dec;
  logic signed [DW-1:0]  xs_inc_w, ys_dec_w;
  logic signed [DW-1:0]  rx2_w, ry2_w, rx2_q4_w;

  logic [PW-1:0]         ex, ey;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == mer_pkg::ST_IDLE);
  assign out_load = (state_q == mer_pkg::ST_EMIT) && (!out_vld_q || out_o.ready);

  assign rx_wide = RIW'(in_i.rad_x);
  assign ry_wide = RIW'(in_i.rad_y);
  assign rx_in   = rx_wide[RB-1:0];
  assign ry_in   = ry_wide[RB-1:0];
  assign y_m1    = y_q - RB'(1);

  assign mul_p = mul_a * mul_b;
  assign mul_s = $signed({1'b0, mul_p});

  assign two_rx2  = $signed({{(SW-SQW-1){1'b0}}, rx2_q, 1'b0});
  assign two_ry2  = $signed({{(SW-SQW-1){1'b0}}, ry2_q, 1'b0});
  assign xs_inc   = xs_q + two_ry2;
  assign ys_dec   = ys_q - two_rx2;
  assign xs_inc_w = $signed({{(DW-SW){xs_inc[SW-1]}}, xs_inc});
  assign ys_dec_w = $signed({{(DW-SW){ys_dec[SW-1]}}, ys_dec});
  assign rx2_w    = $signed({{(DW-SQW){1'b0}}, rx2_q});
  assign ry2_w    = $signed({{(DW-SQW){1'b0}}, ry2_q});
  assign rx2_q4_w = $signed({{(DW-SQW+2){1'b0}}, rx2_q[SQW-1:2]});

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mer_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.action == mer_pkg::ACT_START) begin
            state_d = mer_pkg::ST_SQ_RX;
          end else if (!active_q) begin
            state_d = mer_pkg::ST_EMIT;
          end else if (r2_q || (xs_q <= ys_q)) begin
            state_d = mer_pkg::ST_STEP;
          end else begin
            state_d = mer_pkg::ST_SEED_XX;
          end
        end
      end
      mer_pkg::ST_SQ_RX:   state_d = mer_pkg::ST_SQ_RY;
      mer_pkg::ST_SQ_RY:   state_d = mer_pkg::ST_YTERM;
      mer_pkg::ST_YTERM:   state_d = mer_pkg::ST_EMIT;
      mer_pkg::ST_SEED_XX: state_d = mer_pkg::ST_SEED_A;
      mer_pkg::ST_SEED_A:  state_d = mer_pkg::ST_SEED_YY;
      mer_pkg::ST_SEED_YY: state_d = mer_pkg::ST_SEED_B;
      mer_pkg::ST_SEED_B:  state_d = mer_pkg::ST_SEED_C;
      mer_pkg::ST_SEED_C:  state_d = mer_pkg::ST_STEP;
      mer_pkg::ST_STEP:    state_d = mer_pkg::ST_EMIT;
      mer_pkg::ST_EMIT: begin
        if (out_load) begin
          state_d = mer_pkg::ST_IDLE;
        end
      end
      default:             state_d = mer_pkg::ST_IDLE;
    endcase
  end

  // Datapath and shared multiplier operands
  always_comb begin
    kind_d   = kind_q;
    active_d = active_q;
    r2_d     = r2_q;
    last_d   = last_q;
    x_d      = x_q;
    y_d      = y_q;
    xs_d     = xs_q;
    ys_d     = ys_q;
    dec_d    = dec_q;
    rx2_d    = rx2_q;
    ry2_d    = ry2_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    csx_d    = csx_q;
    csy_d    = csy_q;
    tmp_d    = tmp_q;
    mul_a    = '0;
    mul_b    = '0;

    unique case (state_q)
      mer_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.action == mer_pkg::ACT_START) begin
            csx_d = {{(PW-OW){1'b0}}, org_x_q}
                  + {{(PW-CW){in_i.center_x[CW-1]}}, in_i.center_x};
            csy_d = {{(PW-OW){1'b0}}, org_y_q}
                  - {{(PW-CW){in_i.center_y[CW-1]}}, in_i.center_y};
            rx_d  = rx_in;
            ry_d  = ry_in;
            x_d   = '0;
            y_d   = ry_in;
            xs_d  = '0;
            r2_d  = 1'b0;
          end else if (!active_q) begin
            kind_d = mer_pkg::EM_NULL;
            last_d = 1'b0;
          end
        end
      end
      mer_pkg::ST_SQ_RX: begin
        mul_a = MAW'(rx_q);
        mul_b = MBW'(rx_q);
        rx2_d = mul_p[SQW-1:0];
      end
      mer_pkg::ST_SQ_RY: begin
        mul_a = MAW'(ry_q);
        mul_b = MBW'(ry_q);
        ry2_d = mul_p[SQW-1:0];
      end
      mer_pkg::ST_YTERM: begin
        mul_a    = rx2_q;
        mul_b    = MBW'(ry_q);
        ys_d     = $signed({mul_p[SW-2:0], 1'b0});
        dec_d    = ry2_w - mul_s + rx2_q4_w;
        active_d = (rx_q != '0) && (ry_q != '0);
        last_d   = (rx_q == '0) || (ry_q == '0);
        kind_d   = mer_pkg::EM_AXIS;
      end
      mer_pkg::ST_SEED_XX: begin
        mul_a = MAW'(x_q);
        mul_b = MBW'(x_q) + MBW'(1);
        tmp_d = mul_p[MBW-1:0];
      end
      mer_pkg::ST_SEED_A: begin
        mul_a = ry2_q;
        mul_b = tmp_q;
        dec_d = mul_s;
      end
      mer_pkg::ST_SEED_YY: begin
        mul_a = MAW'(y_m1);
        mul_b = MBW'(y_m1);
        tmp_d = mul_p[MBW-1:0];
      end
      mer_pkg::ST_SEED_B: begin
        mul_a = rx2_q;
        mul_b = tmp_q;
        dec_d = dec_q + mul_s;
      end
      mer_pkg::ST_SEED_C: begin
        mul_a = rx2_q;
        mul_b = MBW'(ry2_q);
        dec_d = dec_q - mul_s;
        r2_d  = 1'b1;
      end
      mer_pkg::ST_STEP: begin
        if (!r2_q) begin
          x_d  = x_q + XW'(1);
          xs_d = xs_inc;
          if (dec_q[DW-1]) begin
            dec_d = dec_q + xs_inc_w + ry2_w;
            y_d   = y_q;
          end else begin
            ys_d  = ys_dec;
            dec_d = dec_q + xs_inc_w + ry2_w - ys_dec_w;
            y_d   = y_m1;
          end
          kind_d = mer_pkg::EM_STEP;
          last_d = (y_d == '0);
        end else if (y_q == '0) begin
          // region 2 already at the axis: drop the ellipse, empty result
          kind_d = mer_pkg::EM_NULL;
          last_d = 1'b0;
        end else begin
          y_d  = y_m1;
          ys_d = ys_dec;
          if (dec_q > 0) begin
            dec_d = dec_q + rx2_w - ys_dec_w;
          end else begin
            xs_d  = xs_inc;
            dec_d = dec_q + rx2_w - ys_dec_w + xs_inc_w;
            x_d   = x_q + XW'(1);
          end
          kind_d = mer_pkg::EM_STEP;
          last_d = (y_d == '0);
        end
        if ((y_d == '0) || (r2_q && (y_q == '0))) begin
          active_d = 1'b0;
        end
      end
      mer_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Result formatting for the output register
  always_comb begin
    ex = PW'(x_q);
    ey = PW'(y_q);
    out_pv_d = 1'b1;
    unique case (kind_q)
      mer_pkg::EM_AXIS: begin
        opt_d[0] = csx_q;             opt_d[1] = csy_q + PW'(ry_q);
        opt_d[2] = csx_q;             opt_d[3] = csy_q - PW'(ry_q);
        opt_d[4] = csx_q + PW'(rx_q); opt_d[5] = csy_q;
        opt_d[6] = csx_q - PW'(rx_q); opt_d[7] = csy_q;
      end
      mer_pkg::EM_STEP: begin
        opt_d[0] = csx_q + ex; opt_d[1] = csy_q + ey;
        opt_d[2] = csx_q + ex; opt_d[3] = csy_q - ey;
        opt_d[4] = csx_q - ex; opt_d[5] = csy_q + ey;
        opt_d[6] = csx_q - ex; opt_d[7] = csy_q - ey;
      end
      default: begin
        for (int i = 0; i < 8; i++) begin
          opt_d[i] = '0;
        end
        out_pv_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mer_pkg::ST_IDLE;
      kind_q   <= mer_pkg::EM_NULL;
      active_q <= 1'b0;
      r2_q     <= 1'b0;
      last_q   <= 1'b0;
      x_q      <= '0;
      y_q      <= '0;
      xs_q     <= '0;
      ys_q     <= '0;
      dec_q    <= '0;
      rx2_q    <= '0;
      ry2_q    <= '0;
      rx_q     <= '0;
      ry_q     <= '0;
      csx_q    <= '0;
      csy_q    <= '0;
      tmp_q    <= '0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      active_q <= active_d;
      r2_q     <= r2_d;
      last_q   <= last_d;
      x_q      <= x_d;
      y_q      <= y_d;
      xs_q     <= xs_d;
      ys_q     <= ys_d;
      dec_q    <= dec_d;
      rx2_q    <= rx2_d;
      ry2_q    <= ry2_d;
      rx_q     <= rx_d;
      ry_q     <= ry_d;
      csx_q    <= csx_d;
      csy_q    <= csy_d;
      tmp_q    <= tmp_d;
    end
  end

  // Origin registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= mer_pkg::ORIGIN_RESET;
      org_y_q <= mer_pkg::ORIGIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mer_pkg::CFG_ORIGIN_X: org_x_q <= cfg_data_i;
        mer_pkg::CFG_ORIGIN_Y: org_y_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int i = 0; i < 8; i++) begin
        opt_q[i] <= opt_d[i];
      end
      out_pv_q   <= out_pv_d;
      out_last_q <= last_q;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.pt0_x        = opt_q[0];
  assign out_o.pt0_y        = opt_q[1];
  assign out_o.pt1_x        = opt_q[2];
  assign out_o.pt1_y        = opt_q[3];
  assign out_o.pt2_x        = opt_q[4];
  assign out_o.pt2_y        = opt_q[5];
  assign out_o.pt3_x        = opt_q[6];
  assign out_o.pt3_y        = opt_q[7];
  assign out_o.points_valid = out_pv_q;
  assign out_o.last_step    = out_last_q;

  a_load_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == mer_pkg::ST_EMIT)
    else $error("output register loaded outside the emit state");

  a_step_needs_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mer_pkg::ST_STEP || state_q == mer_pkg::ST_SEED_XX) |-> active_q)
    else $error("step or seed without an ellipse in progress");

  a_y_never_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mer_pkg::ST_IDLE) |=> (y_q <= $past(y_q)))
    else $error("y coordinate grew outside a start");

  a_null_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_pv_q) |-> !out_last_q)
    else $error("empty result flagged as last");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for the midpoint ellipse raster unit: predicts every point set
// and compares it on the output channel. Depends on mer_pkg, mer_in_if, mer_out_if.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 20;

  localparam int CTR_W     = mer_pkg::CTR_W;
  localparam int RAD_W     = mer_pkg::RAD_W;
  localparam int PT_W      = mer_pkg::PT_W;
  localparam int ORG_W     = mer_pkg::ORG_W;
  localparam int CFG_IDX_W = mer_pkg::CFG_IDX_W;

  typedef struct packed {
    mer_pkg::act_e    action;
    logic [CTR_W-1:0] center_x;
    logic [CTR_W-1:0] center_y;
    logic [RAD_W-1:0] rad_x;
    logic [RAD_W-1:0] rad_y;
  } ellipse_cmd_t;

  typedef struct packed {
    logic [PT_W-1:0] pt0_x;
    logic [PT_W-1:0] pt0_y;
    logic [PT_W-1:0] pt1_x;
    logic [PT_W-1:0] pt1_y;
    logic [PT_W-1:0] pt2_x;
    logic [PT_W-1:0] pt2_y;
    logic [PT_W-1:0] pt3_x;
    logic [PT_W-1:0] pt3_y;
    logic            points_valid;
    logic            last_step;
  } point_set_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ORG_W-1:0] cfg_data_i;

  mer_in_if  in_ch ();
  mer_out_if out_ch ();

  midpoint_ellipse_raster_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Predicted rasterizer state
  logic [ORG_W-1:0] origin_col = mer_pkg::ORIGIN_RESET;
  logic [ORG_W-1:0] origin_row = mer_pkg::ORIGIN_RESET;
  bit     trace_on = 1'b0;
  bit     lower_arc = 1'b0;
  longint arc_x = 0;
  longint arc_y = 0;
  longint x_slope = 0;
  longint y_slope = 0;
  longint midpoint_err = 0;
  longint rx_sq = 0;
  longint ry_sq = 0;
  longint centre_col = 0;
  longint centre_row = 0;

  point_set_t  pending_points[$];
  int          error_count = 0;
  int          burst_left = 0;
  int unsigned cycle_count = 0;

  function automatic point_set_t screen_pts(input longint a0, a1, b0, b1,
                                            input longint c0, c1, d0, d1);
    point_set_t r;
    r = '0;
    r.pt0_x = a0[PT_W-1:0];
    r.pt0_y = a1[PT_W-1:0];
    r.pt1_x = b0[PT_W-1:0];
    r.pt1_y = b1[PT_W-1:0];
    r.pt2_x = c0[PT_W-1:0];
    r.pt2_y = c1[PT_W-1:0];
    r.pt3_x = d0[PT_W-1:0];
    r.pt3_y = d1[PT_W-1:0];
    r.points_valid = 1'b1;
    return r;
  endfunction

  // Advance the predicted rasterizer by one command and return its point set
  function automatic point_set_t raster_step(input ellipse_cmd_t c);
    point_set_t r;
    longint rx;
    longint ry;
    r = '0;
    if (c.action == mer_pkg::ACT_START) begin
      rx = longint'(c.rad_x);
      ry = longint'(c.rad_y);
      centre_col = longint'(origin_col) + longint'($signed(c.center_x));
      centre_row = longint'(origin_row) - longint'($signed(c.center_y));
      rx_sq = rx * rx;
      ry_sq = ry * ry;
      arc_x = 0;
      arc_y = ry;
      x_slope = 0;
      y_slope = 2 * rx_sq * ry;
      midpoint_err = ry_sq - rx_sq * ry + (rx_sq >> 2);
      lower_arc = 1'b0;
      trace_on = (rx != 0) && (ry != 0);
      r = screen_pts(centre_col, centre_row + ry, centre_col, centre_row - ry,
                     centre_col + rx, centre_row, centre_col - rx, centre_row);
      r.last_step = !trace_on;
      return r;
    end
    if (!trace_on) return r;
    if (!lower_arc && x_slope <= y_slope) begin
      arc_x++;
      x_slope += 2 * ry_sq;
      if (midpoint_err < 0) begin
        midpoint_err += x_slope + ry_sq;
      end else begin
        y_slope -= 2 * rx_sq;
        midpoint_err += x_slope + ry_sq - y_slope;
        arc_y--;
      end
    end else begin
      if (!lower_arc) begin
        // seed the second region with the half-pixel offset on x
        lower_arc = 1'b1;
        midpoint_err = ry_sq * (arc_x * arc_x + arc_x)
                     + rx_sq * (arc_y - 1) * (arc_y - 1) - rx_sq * ry_sq;
      end
      if (arc_y <= 0) begin
        trace_on = 1'b0;
        return r;
      end
      arc_y--;
      y_slope -= 2 * rx_sq;
      if (midpoint_err > 0) begin
        midpoint_err += rx_sq - y_slope;
      end else begin
        x_slope += 2 * ry_sq;
        midpoint_err += rx_sq - y_slope + x_slope;
        arc_x++;
      end
    end
    r = screen_pts(centre_col + arc_x, centre_row + arc_y, centre_col + arc_x,
                   centre_row - arc_y, centre_col - arc_x, centre_row + arc_y,
                   centre_col - arc_x, centre_row - arc_y);
    if (arc_y <= 0) begin
      r.last_step = 1'b1;
      trace_on = 1'b0;
    end
    return r;
  endfunction

  function automatic ellipse_cmd_t start_cmd(input int cx, cy, rx, ry);
    ellipse_cmd_t c;
    c.action = mer_pkg::ACT_START;
    c.center_x = CTR_W'(cx);
    c.center_y = CTR_W'(cy);
    c.rad_x = RAD_W'(rx);
    c.rad_y = RAD_W'(ry);
    return c;
  endfunction

  // Advance commands carry random payload that the unit must ignore
  function automatic ellipse_cmd_t advance_cmd();
    ellipse_cmd_t c;
    c = start_cmd($urandom, $urandom, $urandom, $urandom);
    c.action = mer_pkg::ACT_ADVANCE;
    return c;
  endfunction

  // Send one command, with a random gap at the start of each burst
  task automatic issue(input ellipse_cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_ch.valid    = 1'b1;
    in_ch.action   = c.action;
    in_ch.center_x = c.center_x;
    in_ch.center_y = c.center_y;
    in_ch.rad_x    = c.rad_x;
    in_ch.rad_y    = c.rad_y;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_points.push_back(raster_step(c));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_origin(input logic [ORG_W-1:0] col, input logic [ORG_W-1:0] row);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = mer_pkg::CFG_ORIGIN_X;
    cfg_data_i = col;
    @(negedge clk_i);
    cfg_idx_i  = mer_pkg::CFG_ORIGIN_Y;
    cfg_data_i = row;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    origin_col = col;
    origin_row = row;
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Idle advances, zero radii at both extremes, then a start that gets abandoned
  task automatic test_idle_and_axis();
    issue(advance_cmd());
    issue(start_cmd(0, 0, 0, 0));
    issue(advance_cmd());
    issue(start_cmd(-1024, 1023, 1023, 0));
    issue(start_cmd(1023, -1024, 0, 1023));
    issue(start_cmd(5, -7, 1023, 1023));
    issue(advance_cmd());
    issue(advance_cmd());
  endtask

  // A tall ellipse crosses into the second region; a start also cuts a trace short
  task automatic test_full_ellipse();
    issue(start_cmd(-3, 4, 2, 3));
    while (trace_on) issue(advance_cmd());
    issue(advance_cmd());
    issue(start_cmd(10, 20, 5, 7));
    repeat (3) issue(advance_cmd());
    issue(start_cmd(-10, -20, 3, 2));
    while (trace_on) issue(advance_cmd());
  endtask

  // Extreme origins push screen points toward both ends of the 14-bit range
  task automatic test_screen_wrap();
    set_origin(12'd4095, 12'd0);
    issue(start_cmd(1023, -1024, 1023, 1023));
    issue(advance_cmd());
    set_origin(12'd0, 12'd4095);
    issue(start_cmd(-1024, 1023, 1023, 1023));
    issue(advance_cmd());
  endtask

  task automatic test_random_traces();
    int counted;
    int kind;
    int sel;
    int rx;
    int ry;
    int budget;
    int steps;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_origin(12'd0, 12'd0);
        1: set_origin(12'd4095, 12'd4095);
        default: set_origin(ORG_W'($urandom), ORG_W'($urandom));
      endcase
      counted = 0;
      while (counted < 85) begin
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
          issue(advance_cmd());
        end else if (kind < 4) begin
          if ($urandom_range(0, 1) == 0) issue(start_cmd($urandom, $urandom, 0, $urandom));
          else issue(start_cmd($urandom, $urandom, $urandom, 0));
          counted++;
        end else begin
          sel = $urandom_range(0, 9);
          if (sel == 0) begin
            rx = $urandom_range(0, 1023);
            ry = $urandom_range(0, 1023);
            budget = $urandom_range(1, 20);
          end else begin
            rx = (sel < 3) ? $urandom_range(16, 63) : $urandom_range(1, 15);
            ry = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 63) : $urandom_range(1, 15);
            budget = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 100000;
          end
          issue(start_cmd($urandom, $urandom, rx, ry));
          counted++;
          steps = 0;
          while (trace_on && steps < budget) begin
            issue(advance_cmd());
            steps++;
            counted++;
          end
        end
      end
    end
  endtask

  // Output receiver: switch between no stalls, short stalls and long stalls
  initial begin : receiver
    int stall_left;
    int mode_left;
    int mode;
    out_ch.ready = 1'b0;
    stall_left = 0;
    mode_left = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (mode == 1 && $urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ch.ready = 1'b0;
      end else if (mode == 2 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(3, 11);
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    point_set_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_points.size() == 0) begin
        $error("point set transfer with no pending prediction");
        error_count++;
      end else begin
        want = pending_points.pop_front();
        compare_field("pt0_x", $signed(want.pt0_x), out_ch.pt0_x);
        compare_field("pt0_y", $signed(want.pt0_y), out_ch.pt0_y);
        compare_field("pt1_x", $signed(want.pt1_x), out_ch.pt1_x);
        compare_field("pt1_y", $signed(want.pt1_y), out_ch.pt1_y);
        compare_field("pt2_x", $signed(want.pt2_x), out_ch.pt2_x);
        compare_field("pt2_y", $signed(want.pt2_y), out_ch.pt2_y);
        compare_field("pt3_x", $signed(want.pt3_x), out_ch.pt3_x);
        compare_field("pt3_y", $signed(want.pt3_y), out_ch.pt3_y);
        compare_field("points_valid", want.points_valid, out_ch.points_valid);
        compare_field("last_step", want.last_step, out_ch.last_step);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = mer_pkg::CFG_ORIGIN_X;
    cfg_data_i     = '0;
    in_ch.valid    = 1'b0;
    in_ch.action   = mer_pkg::ACT_START;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.rad_x    = '0;
    in_ch.rad_y    = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_and_axis();
    test_full_ellipse();
    test_screen_wrap();
    test_random_traces();

    wait_drained();
    // hold a few cycles to catch any stray transfer
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
